// ===== rtl/drop_oldest_deque_with_byte_count_unit_defines.svh =====
// Assertion macros shared by the deque unit.
`ifndef DROP_OLDEST_DEQUE_WITH_BYTE_COUNT_UNIT_DEFINES_SVH
`define DROP_OLDEST_DEQUE_WITH_BYTE_COUNT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define DODQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("deque unit assertion failed");
// Checked on every clock edge, reset included.
`define DODQ_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("deque unit reset assertion failed");
`else
`define DODQ_ASSERT(label, prop)
`define DODQ_ASSERT_RST(label, prop)
`endif

`endif

// ===== rtl/dodq_pkg.sv =====
// Shared constants, types and ring helpers of the deque unit.
package dodq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;
    localparam int CMD_W       = 2;
    localparam int TAG_W       = 32;
    localparam int SIZE_W      = 16;
    localparam int TOTAL_W     = 24;
    localparam int COUNT_OUT_W = 9;
    localparam int ENTRY_W     = TAG_W + SIZE_W;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUTBACK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic                   accepted;
        logic                   entry_valid;
        logic [TAG_W-1:0]       out_tag;
        logic [SIZE_W-1:0]      out_size;
        logic                   dropped;
        logic [TAG_W-1:0]       dropped_tag;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [TOTAL_W-1:0]     bytes_in_queue;
    } t_result;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(QUEUE_DEPTH - 1) : idx - IDX_W'(1);
    endfunction

endpackage

// ===== rtl/dodq_if.sv =====
// Request and response channel interfaces of the deque unit.
interface dodq_req_if import dodq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TAG_W-1:0]  entry_tag;
    logic [SIZE_W-1:0] entry_size;

    modport source (output valid, output command, output entry_tag, output entry_size,
                    input ready);
    modport sink   (input valid, input command, input entry_tag, input entry_size,
                    output ready);
endinterface

interface dodq_rsp_if import dodq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic                   entry_valid;
    logic [TAG_W-1:0]       out_tag;
    logic [SIZE_W-1:0]      out_size;
    logic                   dropped;
    logic [TAG_W-1:0]       dropped_tag;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [TOTAL_W-1:0]     bytes_in_queue;

    modport source (output valid, output accepted, output entry_valid, output out_tag,
                    output out_size, output dropped, output dropped_tag,
                    output entry_count, output bytes_in_queue, input ready);
    modport sink   (input valid, input accepted, input entry_valid, input out_tag,
                    input out_size, input dropped, input dropped_tag,
                    input entry_count, input bytes_in_queue, output ready);
endinterface

// ===== rtl/dodq_ram.sv =====
// Simple dual-port RAM with registered, write-first read.
module dodq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A write to the address being read is forwarded into the registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dodq_ctrl.sv =====
// Queue pointer, count, byte total and head-entry logic of the deque unit.
module dodq_ctrl import dodq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_enabled,
    input  logic [CMD_W-1:0]  i_command,
    input  t_entry            i_entry,
    input  t_entry            i_next_ent,
    output t_ram_ctl          o_ram,
    output t_result           o_result
);

    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [TOTAL_W-1:0] r_total;
    t_entry             r_head_ent;

    logic [IDX_W-1:0]   n_head;
    logic [CNT_W-1:0]   n_count;
    logic [TOTAL_W-1:0] n_total;
    t_entry             n_head_ent;

    logic               is_ins;
    logic               is_deq;
    logic               full;
    logic               pop;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail_slot;
    logic [TOTAL_W-1:0] total_after_pop;

    always_comb begin
        is_ins = i_enabled && ((i_command == CMD_ENQUEUE) || (i_command == CMD_PUTBACK));
        is_deq = i_enabled && (i_command == CMD_DEQUEUE) && (r_count != '0);
        full   = (r_count == CNT_W'(QUEUE_DEPTH));
        pop    = is_deq || (is_ins && full);

        // Tail slot of a queue that is not full; below twice the depth.
        tail_sum  = {1'b0, r_head} + SUM_W'(r_count);
        tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

        total_after_pop = pop ? (r_total - TOTAL_W'(r_head_ent.size)) : r_total;

        n_head      = r_head;
        n_count     = r_count;
        n_total     = r_total;
        n_head_ent  = r_head_ent;
        o_ram.we    = 1'b0;
        o_ram.waddr = tail_slot;
        o_ram.wdata = i_entry;

        if (i_accept) begin
            if (is_deq) begin
                n_head     = ring_next(r_head);
                n_count    = r_count - CNT_W'(1);
                n_total    = total_after_pop;
                n_head_ent = i_next_ent;
            end else if (is_ins) begin
                o_ram.we = 1'b1;
                n_total  = total_after_pop + TOTAL_W'(i_entry.size);
                if (!full) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (i_command == CMD_PUTBACK) begin
                    // On a full queue the dropped head slot is reused by the new head.
                    o_ram.waddr = full ? r_head : ring_prev(r_head);
                    n_head      = full ? r_head : ring_prev(r_head);
                    n_head_ent  = i_entry;
                end else if (full) begin
                    // The ring wraps: the new tail lands in the dropped head slot.
                    o_ram.waddr = r_head;
                    n_head      = ring_next(r_head);
                    n_head_ent  = i_next_ent;
                end else if (r_count == '0) begin
                    n_head_ent = i_entry;
                end
            end
        end

        // Keep the entry behind the head prefetched for the next pop.
        o_ram.raddr = ring_next(n_head);

        o_result.accepted       = is_ins;
        o_result.entry_valid    = is_deq;
        o_result.out_tag        = is_deq ? r_head_ent.tag : '0;
        o_result.out_size       = is_deq ? r_head_ent.size : '0;
        o_result.dropped        = is_ins && full;
        o_result.dropped_tag    = (is_ins && full) ? r_head_ent.tag : '0;
        o_result.entry_count    = COUNT_OUT_W'(n_count);
        o_result.bytes_in_queue = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_ent <= n_head_ent;
    end

endmodule

// ===== rtl/drop_oldest_deque_with_byte_count_unit.sv =====
// Top level of the bounded drop-oldest deque with running byte count.
//
//  Channel   Direction  Handshake             Payload
//  i_req     in         valid/ready           command, entry_tag, entry_size
//  o_rsp     out        valid/ready           accepted, entry_valid, out_tag, out_size,
//                                             dropped, dropped_tag, entry_count,
//                                             bytes_in_queue
//  i_cfg     in         write enable only     queue_enabled (one bit)
//
// Each request is handled in the cycle it is accepted and its response sits in the output
// register in the next cycle; the unit sustains one request per cycle while o_rsp.ready is
// high. That rate rests on updating the head pointer, the count and the byte total in the
// accept cycle, with the entry behind the head kept prefetched from the entry RAM. Reset
// is synchronous and active low; it empties the queue and sets queue_enabled. A stalled
// response holds in the output register; a new request is taken in the cycle it leaves.
`include "drop_oldest_deque_with_byte_count_unit_defines.svh"

module drop_oldest_deque_with_byte_count_unit import dodq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    dodq_req_if.sink   i_req,
    dodq_rsp_if.source o_rsp
);

    logic     r_enabled;
    logic     r_out_valid;
    t_result  r_out;

    logic     req_accept;
    t_entry   req_entry;
    t_entry   next_ent;
    t_ram_ctl ram_ctl;
    t_result  result;

    // The user must write the configuration bit only with no request in flight; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    // A request is taken whenever the output register is empty or being emptied.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_accept  = i_req.valid && i_req.ready;

    assign req_entry.tag  = i_req.entry_tag;
    assign req_entry.size = i_req.entry_size;

    dodq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (req_accept),
        .i_enabled  (r_enabled),
        .i_command  (i_req.command),
        .i_entry    (req_entry),
        .i_next_ent (next_ent),
        .o_ram      (ram_ctl),
        .o_result   (result)
    );

    // Entry storage: one write port for the inserted entry and one read port that
    // tracks the slot just behind the head.
    dodq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (ram_ctl.waddr),
        .i_wdata (ram_ctl.wdata),
        .i_raddr (ram_ctl.raddr),
        .o_rdata (next_ent)
    );

    // Output register: loaded with the response of each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_out.accepted;
    assign o_rsp.entry_valid    = r_out.entry_valid;
    assign o_rsp.out_tag        = r_out.out_tag;
    assign o_rsp.out_size       = r_out.out_size;
    assign o_rsp.dropped        = r_out.dropped;
    assign o_rsp.dropped_tag    = r_out.dropped_tag;
    assign o_rsp.entry_count    = r_out.entry_count;
    assign o_rsp.bytes_in_queue = r_out.bytes_in_queue;

    // Every accepted request leaves a response in the output register.
    `DODQ_ASSERT(a_req_gives_rsp, (i_req.valid && i_req.ready) |=> o_rsp.valid)

    // A drop happens only on a taken insert into a full queue.
    `DODQ_ASSERT(a_drop_when_full, (o_rsp.valid && o_rsp.dropped) |->
        (o_rsp.accepted && (o_rsp.entry_count == COUNT_OUT_W'(QUEUE_DEPTH))))

    // While disabled, no request inserts or returns an entry.
    `DODQ_ASSERT(a_disabled_refuses, (i_req.valid && i_req.ready && !r_enabled) |=>
        (!o_rsp.accepted && !o_rsp.entry_valid))

    // Reset leaves no response pending.
    `DODQ_ASSERT_RST(a_reset_clears_rsp, !i_rst_n |=> !o_rsp.valid)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the drop-oldest deque unit with its running byte count.
module tb_top import dodq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // The command encoding leaves one code unused; the unit treats it as a no-op.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam logic QUEUE_OFF = 1'b0;
    localparam logic QUEUE_ON  = 1'b1;

    // The response comes from the output register; SETTLE_CYCLES covers any output register slack.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_GUARD   = 20000;
    localparam int RANDOM_ITEMS  = 1000;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } t_row_kind;

    // One line of the directed table. Rows with typed set carry a hand-written response;
    // the rest are checked against the shadow deque.
    typedef struct {
        t_row_kind         kind;
        logic              enable_value;
        logic [CMD_W-1:0]  command;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        bit                typed;
        t_result           want;
    } t_stim_row;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_DISABLED
    } t_traffic_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    dodq_req_if req_ch ();
    dodq_rsp_if rsp_ch ();

    drop_oldest_deque_with_byte_count_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the deque: ring storage, head pointer, occupancy, byte total and
    // the enable bit, all as they stand after the last accepted request.
    t_entry                shadow_ring [QUEUE_DEPTH];
    int                    shadow_head    = 0;
    int                    shadow_count   = 0;
    logic [TOTAL_W-1:0]    shadow_bytes   = '0;
    logic                  shadow_enabled = QUEUE_ON;

    // Responses the unit still owes, oldest first.
    t_result outstanding_responses [$];

    int  mismatches  = 0;
    bit  quiet_phase = 1'b0;

    // Applies one request to the shadow deque and returns the response it should produce.
    function automatic t_result shadow_deque_op(input logic [CMD_W-1:0] cmd,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [SIZE_W-1:0] size);
        t_result r;
        int      slot;
        r = '0;
        if ((cmd == CMD_ENQUEUE || cmd == CMD_PUTBACK) && shadow_enabled) begin
            // A full queue gives up its oldest entry before anything is inserted, so the
            // dropped size leaves the total before the new size joins it.
            if (shadow_count >= QUEUE_DEPTH) begin
                r.dropped     = 1'b1;
                r.dropped_tag = shadow_ring[shadow_head].tag;
                shadow_bytes  = shadow_bytes - TOTAL_W'(shadow_ring[shadow_head].size);
                shadow_head   = (shadow_head + 1) % QUEUE_DEPTH;
                shadow_count--;
            end
            if (cmd == CMD_ENQUEUE) begin
                slot = (shadow_head + shadow_count) % QUEUE_DEPTH;
            end else begin
                // Put-back lands in front of the head and becomes the new head.
                slot        = (shadow_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                shadow_head = slot;
            end
            shadow_ring[slot] = {tag, size};
            shadow_count++;
            shadow_bytes = shadow_bytes + TOTAL_W'(size);
            r.accepted   = 1'b1;
        end else if (cmd == CMD_DEQUEUE && shadow_enabled && shadow_count != 0) begin
            r.entry_valid = 1'b1;
            r.out_tag     = shadow_ring[shadow_head].tag;
            r.out_size    = shadow_ring[shadow_head].size;
            shadow_bytes  = shadow_bytes - TOTAL_W'(shadow_ring[shadow_head].size);
            shadow_head   = (shadow_head + 1) % QUEUE_DEPTH;
            shadow_count--;
        end
        r.entry_count    = COUNT_OUT_W'(shadow_count);
        r.bytes_in_queue = shadow_bytes;
        return r;
    endfunction

    function automatic t_result rsp_of(input logic acc, input logic valid,
                                       input logic [TAG_W-1:0] otag,
                                       input logic [SIZE_W-1:0] osize,
                                       input logic drop, input logic [TAG_W-1:0] dtag,
                                       input logic [COUNT_OUT_W-1:0] count,
                                       input logic [TOTAL_W-1:0] bytes);
        return {acc, valid, otag, osize, drop, dtag, count, bytes};
    endfunction

    function automatic t_stim_row typed_row(input logic [CMD_W-1:0] cmd,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [SIZE_W-1:0] size,
                                            input t_result want);
        t_stim_row row;
        row.kind         = ROW_REQUEST;
        row.enable_value = QUEUE_ON;
        row.command      = cmd;
        row.tag          = tag;
        row.size         = size;
        row.typed        = 1'b1;
        row.want         = want;
        return row;
    endfunction

    function automatic t_stim_row predicted_row(input logic [CMD_W-1:0] cmd,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [SIZE_W-1:0] size);
        t_stim_row row;
        row       = typed_row(cmd, tag, size, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic t_stim_row enable_row(input logic value);
        t_stim_row row;
        row              = typed_row(CMD_NOP, '0, '0, '0);
        row.kind         = ROW_CONFIG;
        row.enable_value = value;
        row.typed        = 1'b0;
        return row;
    endfunction

    // Idle stretch length: mostly none, otherwise a short one, now and then a long one.
    // Quiet phases run back to back with no idling at all.
    function automatic int idle_len();
        int roll;
        if (quiet_phase) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Tags and sizes lean toward the extremes now and then so the all-zero and all-one
    // patterns come up in both fields.
    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return SIZE_W'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Presents one request, holds it until the unit takes it, and records the response
    // it owes. The step in which the request is taken is the step the task returns in,
    // so a following request can keep valid high without a gap.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                input logic [SIZE_W-1:0] size, input bit typed,
                                input t_result want);
        int      gap;
        t_result predicted;
        gap = idle_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.entry_tag  <= tag;
        req_ch.entry_size <= size;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        // The shadow deque always advances, even where the response is typed in by hand.
        predicted = shadow_deque_op(cmd, tag, size);
        outstanding_responses.push_back(typed ? want : predicted);
    endtask

    // The enable bit is only written with the unit idle: nothing owed and the output
    // register given time to empty.
    task automatic write_queue_enable(input logic value);
        req_ch.valid <= 1'b0;
        while (outstanding_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        shadow_enabled  = value;
    endtask

    // Response side: ready drops for random stretches, with quiet phases holding it high.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Every response taken is compared field by field with the oldest one owed.
    always @(posedge i_clk) begin : rsp_check
        t_result got;
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.accepted, rsp_ch.entry_valid, rsp_ch.out_tag, rsp_ch.out_size,
                   rsp_ch.dropped, rsp_ch.dropped_tag, rsp_ch.entry_count,
                   rsp_ch.bytes_in_queue};
            if (outstanding_responses.size() == 0) begin
                $display("%0t ns: response with none owed, expected nothing, actual 0x%0h",
                         $time, got);
                mismatches++;
            end else begin
                want = outstanding_responses.pop_front();
                check_field("accepted",       32'(want.accepted),    32'(got.accepted));
                check_field("entry_valid",    32'(want.entry_valid), 32'(got.entry_valid));
                check_field("out_tag",        want.out_tag,          got.out_tag);
                check_field("out_size",       32'(want.out_size),    32'(got.out_size));
                check_field("dropped",        32'(want.dropped),     32'(got.dropped));
                check_field("dropped_tag",    want.dropped_tag,      got.dropped_tag);
                check_field("entry_count",    32'(want.entry_count), 32'(got.entry_count));
                check_field("bytes_in_queue", 32'(want.bytes_in_queue),
                            32'(got.bytes_in_queue));
            end
        end
    end

    // Hard stop well beyond the slowest legal run: about 1000 requests, each behind a
    // long request gap and a long response stall.
    initial begin
        #(15_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_stim_row    directed_rows [$];
        t_stim_row    row;
        t_traffic_mix mix;
        logic [CMD_W-1:0] cmd;
        int phase;
        int phase_len;
        int insert_pct;
        int roll;
        int sent;
        int guard;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_ENQUEUE;
        req_ch.entry_tag  = '0;
        req_ch.entry_size = '0;

        // Directed table. Everything starts from the empty, enabled queue left by reset.
        // A dequeue and a no-op on the empty queue report nothing and zero counts.
        directed_rows.push_back(typed_row(CMD_DEQUEUE, '0, '0,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd0, 24'd0)));
        directed_rows.push_back(typed_row(CMD_NOP, '1, '1,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd0, 24'd0)));
        // Largest and smallest entries through both insert paths.
        directed_rows.push_back(typed_row(CMD_ENQUEUE, '1, '1,
                                          rsp_of(1'b1, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd1, 24'h00FFFF)));
        directed_rows.push_back(typed_row(CMD_PUTBACK, '0, '0,
                                          rsp_of(1'b1, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd2, 24'h00FFFF)));
        directed_rows.push_back(typed_row(CMD_ENQUEUE, 32'h1234_5678, 16'd1,
                                          rsp_of(1'b1, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd3, 24'h010000)));
        // With the queue disabled, every command is refused and the counts stand still.
        directed_rows.push_back(enable_row(QUEUE_OFF));
        directed_rows.push_back(typed_row(CMD_ENQUEUE, 32'hA5A5_A5A5, 16'h5A5A,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd3, 24'h010000)));
        directed_rows.push_back(typed_row(CMD_PUTBACK, 32'hA5A5_A5A5, 16'h5A5A,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd3, 24'h010000)));
        directed_rows.push_back(typed_row(CMD_DEQUEUE, '0, '0,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd3, 24'h010000)));
        directed_rows.push_back(typed_row(CMD_NOP, '0, '0,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd3, 24'h010000)));
        // Re-enabled: the put-back entry leaves first, then the two enqueued ones in order.
        directed_rows.push_back(enable_row(QUEUE_ON));
        directed_rows.push_back(typed_row(CMD_DEQUEUE, '0, '0,
                                          rsp_of(1'b0, 1'b1, '0, '0, 1'b0, '0,
                                                 9'd2, 24'h010000)));
        directed_rows.push_back(typed_row(CMD_DEQUEUE, '0, '0,
                                          rsp_of(1'b0, 1'b1, '1, '1, 1'b0, '0,
                                                 9'd1, 24'h000001)));
        directed_rows.push_back(typed_row(CMD_DEQUEUE, '0, '0,
                                          rsp_of(1'b0, 1'b1, 32'h1234_5678, 16'd1,
                                                 1'b0, '0, 9'd0, 24'd0)));
        directed_rows.push_back(typed_row(CMD_DEQUEUE, '0, '0,
                                          rsp_of(1'b0, 1'b0, '0, '0, 1'b0, '0,
                                                 9'd0, 24'd0)));
        // Alternating and single-bit patterns, checked against the shadow deque.
        directed_rows.push_back(predicted_row(CMD_ENQUEUE, 32'h5555_5555, 16'h5555));
        directed_rows.push_back(predicted_row(CMD_PUTBACK, 32'hAAAA_AAAA, 16'hAAAA));
        directed_rows.push_back(predicted_row(CMD_ENQUEUE, 32'h8000_0000, 16'h8000));
        directed_rows.push_back(predicted_row(CMD_PUTBACK, 32'h0000_0001, 16'h0001));
        directed_rows.push_back(predicted_row(CMD_NOP, 32'h0F0F_0F0F, 16'hF0F0));
        directed_rows.push_back(predicted_row(CMD_DEQUEUE, 32'hFFFF_0000, 16'h00FF));
        directed_rows.push_back(predicted_row(CMD_DEQUEUE, '0, '0));

        // Reset is held from the start and released exactly once.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG) begin
                write_queue_enable(row.enable_value);
            end else begin
                send_request(row.command, row.tag, row.size, row.typed, row.want);
            end
        end

        // Random traffic in phases. The first phase is insert-heavy and long enough to
        // fill all 256 slots, so both insert paths run into the drop-oldest case; the
        // second drains it down past empty. Later phases mix freely, with one forced
        // disabled phase and others drawn now and then. The run stops once the random
        // request budget is spent, even in the middle of a phase.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 0) begin
                mix = MIX_FILL;
            end else if (phase == 1) begin
                mix = MIX_DRAIN;
            end else if (phase == 2) begin
                mix = MIX_DISABLED;
            end else begin
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    mix = MIX_DISABLED;
                end else if (roll <= 3) begin
                    mix = MIX_FILL;
                end else if (roll <= 6) begin
                    mix = MIX_DRAIN;
                end else begin
                    mix = MIX_BALANCED;
                end
            end

            case (mix)
                MIX_FILL: begin
                    insert_pct = 90;
                    phase_len  = $urandom_range(350, 400);
                end
                MIX_DRAIN: begin
                    insert_pct = 7;
                    phase_len  = $urandom_range(300, 400);
                end
                MIX_BALANCED: begin
                    insert_pct = 48;
                    phase_len  = $urandom_range(80, 200);
                end
                default: begin
                    insert_pct = 48;
                    phase_len  = 30;
                end
            endcase

            if (mix == MIX_DISABLED) begin
                write_queue_enable(QUEUE_OFF);
            end else if (!shadow_enabled || $urandom_range(0, 3) == 0) begin
                write_queue_enable(QUEUE_ON);
            end
            quiet_phase = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    cmd = CMD_NOP;
                end else if (roll < 3 + insert_pct) begin
                    cmd = $urandom_range(0, 1) ? CMD_PUTBACK : CMD_ENQUEUE;
                end else begin
                    cmd = CMD_DEQUEUE;
                end
                send_request(cmd, pick_tag(), pick_size(), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        // Let every owed response arrive, then wait out SETTLE_CYCLES for anything stray.
        req_ch.valid <= 1'b0;
        quiet_phase   = 1'b0;
        guard         = 0;
        while (outstanding_responses.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding_responses.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
